// ===== src/fbc_pkg.sv =====
// Shared types and constants of the frustum box classification unit.
package fbc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int COORD_W    = 16;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int DIST_W     = PAIR_W + 1;
    localparam int OFFSET_SH  = 14;
    localparam int REG_W      = 64;
    localparam int ADDR_W     = 6;
    localparam int IDX_W      = 3;
    localparam int IDX_LSB    = 3;

    typedef enum logic [1:0] {
        CONT_OUTSIDE   = 2'd0,
        CONT_INTERSECT = 2'd1,
        CONT_INSIDE    = 2'd2
    } containment_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nx;
    } plane_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] max_z;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_x;
    } box_t;

    typedef struct packed {
        logic mul;
        logic pair;
        logic sum;
    } pipe_en_t;

    typedef struct packed {
        logic p_neg;
        logic n_nonneg;
    } plane_flags_t;

endpackage

// ===== src/fbc_cfg_regs.sv =====
// APB register file holding the six frustum planes.
module fbc_cfg_regs
    import fbc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [REG_W-1:0]    pwdata,
    output logic [REG_W-1:0]    prdata,
    output logic                pready,
    output plane_t              planes [NUM_PLANES]
);

    logic [REG_W-1:0] plane_reg [NUM_PLANES];
    logic [IDX_W-1:0] idx;
    logic             idx_ok;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[IDX_LSB +: IDX_W];
    assign idx_ok = (idx < IDX_W'(NUM_PLANES));
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PLANES; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (wr_en && idx_ok) begin
            plane_reg[idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (idx_ok) begin
            prdata = plane_reg[idx];
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_PLANES; i++) begin
            planes[i] = plane_t'(plane_reg[i]);
        end
    end

endmodule

// ===== src/fbc_plane_eval.sv =====
// Three-stage pipeline testing a box's p-vertex and n-vertex against one plane.
module fbc_plane_eval
    import fbc_pkg::*;
(
    input  logic         aclk,
    input  plane_t       plane,
    input  box_t         box,
    input  pipe_en_t     en,
    output plane_flags_t flags
);

    logic signed [COORD_W-1:0] n_comp [3];
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    logic signed [COORD_W-1:0] pv [3];
    logic signed [COORD_W-1:0] nv [3];

    logic signed [PROD_W-1:0]  prod_p_next [3];
    logic signed [PROD_W-1:0]  prod_n_next [3];
    logic signed [PROD_W-1:0]  prod_p_reg  [3];
    logic signed [PROD_W-1:0]  prod_n_reg  [3];
    logic signed [COORD_W-1:0] d_reg;

    logic signed [PAIR_W-1:0]  offset;
    logic signed [PAIR_W-1:0]  pair_p_next [2];
    logic signed [PAIR_W-1:0]  pair_n_next [2];
    logic signed [PAIR_W-1:0]  pair_p_reg  [2];
    logic signed [PAIR_W-1:0]  pair_n_reg  [2];

    logic signed [DIST_W-1:0]  dist_p;
    logic signed [DIST_W-1:0]  dist_n;
    plane_flags_t              flags_next;
    plane_flags_t              flags_reg;

    always_comb begin
        n_comp[0] = plane.nx;
        n_comp[1] = plane.ny;
        n_comp[2] = plane.nz;
        lo[0] = box.min_x;
        lo[1] = box.min_y;
        lo[2] = box.min_z;
        hi[0] = box.max_x;
        hi[1] = box.max_y;
        hi[2] = box.max_z;
        for (int k = 0; k < 3; k++) begin
            pv[k]          = n_comp[k][COORD_W-1] ? lo[k] : hi[k];
            nv[k]          = n_comp[k][COORD_W-1] ? hi[k] : lo[k];
            prod_p_next[k] = pv[k] * n_comp[k];
            prod_n_next[k] = nv[k] * n_comp[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            prod_p_reg <= prod_p_next;
            prod_n_reg <= prod_n_next;
            d_reg      <= plane.d;
        end
    end

    always_comb begin
        offset = {{(PAIR_W - COORD_W - OFFSET_SH){d_reg[COORD_W-1]}}, d_reg, OFFSET_SH'(0)};
        pair_p_next[0] = {prod_p_reg[0][PROD_W-1], prod_p_reg[0]}
                       + {prod_p_reg[1][PROD_W-1], prod_p_reg[1]};
        pair_p_next[1] = {prod_p_reg[2][PROD_W-1], prod_p_reg[2]} + offset;
        pair_n_next[0] = {prod_n_reg[0][PROD_W-1], prod_n_reg[0]}
                       + {prod_n_reg[1][PROD_W-1], prod_n_reg[1]};
        pair_n_next[1] = {prod_n_reg[2][PROD_W-1], prod_n_reg[2]} + offset;
    end

    always_ff @(posedge aclk) begin
        if (en.pair) begin
            pair_p_reg <= pair_p_next;
            pair_n_reg <= pair_n_next;
        end
    end

    always_comb begin
        dist_p = {pair_p_reg[0][PAIR_W-1], pair_p_reg[0]}
               + {pair_p_reg[1][PAIR_W-1], pair_p_reg[1]};
        dist_n = {pair_n_reg[0][PAIR_W-1], pair_n_reg[0]}
               + {pair_n_reg[1][PAIR_W-1], pair_n_reg[1]};
        flags_next.p_neg    = dist_p[DIST_W-1];
        flags_next.n_nonneg = !dist_n[DIST_W-1];
    end

    always_ff @(posedge aclk) begin
        if (en.sum) begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

// ===== src/frustum_box_classify_unit.sv =====
// Top level of the frustum box classification unit: pipeline control and result stage.
//
// Accepts one box per clock cycle and passes it through one stage of corner
// selection and multiplies, one of pairwise adds, one of the final add and sign
// test (six planes side by side), and the output register that combines the
// six plane results, in that order. Back-pressure on
// the result channel stalls the pipeline in place; bubbles in it are squeezed out
// so new boxes are still taken while a finished result waits. Planes are loaded
// over the APB port at byte address 8*i and reset to all zero.
module frustum_box_classify_unit
    import fbc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ADDR_W-1:0]           paddr,
    input  logic [REG_W-1:0]            pwdata,
    output logic [REG_W-1:0]            prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [COORD_W-1:0]   s_box_min_x,
    input  logic signed [COORD_W-1:0]   s_box_min_y,
    input  logic signed [COORD_W-1:0]   s_box_min_z,
    input  logic signed [COORD_W-1:0]   s_box_max_x,
    input  logic signed [COORD_W-1:0]   s_box_max_y,
    input  logic signed [COORD_W-1:0]   s_box_max_z,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_containment
);

    plane_t        planes [NUM_PLANES];
    plane_flags_t  flags  [NUM_PLANES];
    box_t          box;
    pipe_en_t      en;
    logic          en_out;

    logic          v_mul_reg;
    logic          v_pair_reg;
    logic          v_sum_reg;
    logic          m_valid_reg;
    containment_t  cont_next;
    containment_t  cont_reg;
    logic          any_out;
    logic          all_in;

    fbc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    assign box.min_x = s_box_min_x;
    assign box.min_y = s_box_min_y;
    assign box.min_z = s_box_min_z;
    assign box.max_x = s_box_max_x;
    assign box.max_y = s_box_max_y;
    assign box.max_z = s_box_max_z;

    assign en_out   = !m_valid_reg || m_ready;
    assign en.sum   = !v_sum_reg   || en_out;
    assign en.pair  = !v_pair_reg  || en.sum;
    assign en.mul   = !v_mul_reg   || en.pair;
    assign s_ready  = en.mul;

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
        fbc_plane_eval u_eval (
            .aclk  (aclk),
            .plane (planes[g]),
            .box   (box),
            .en    (en),
            .flags (flags[g])
        );
    end

    always_comb begin
        any_out = 1'b0;
        all_in  = 1'b1;
        for (int i = 0; i < NUM_PLANES; i++) begin
            any_out = any_out || flags[i].p_neg;
            all_in  = all_in && flags[i].n_nonneg;
        end
        if (any_out) begin
            cont_next = CONT_OUTSIDE;
        end else if (all_in) begin
            cont_next = CONT_INSIDE;
        end else begin
            cont_next = CONT_INTERSECT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_mul_reg   <= 1'b0;
            v_pair_reg  <= 1'b0;
            v_sum_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en.mul) begin
                v_mul_reg <= s_valid;
            end
            if (en.pair) begin
                v_pair_reg <= v_mul_reg;
            end
            if (en.sum) begin
                v_sum_reg <= v_pair_reg;
            end
            if (en_out) begin
                m_valid_reg <= v_sum_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            cont_reg <= cont_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_containment = cont_reg;

endmodule

// ===== src/fbc_checker.sv =====
// Port-level checks of the frustum box classification unit and their binding.
module fbc_checker
    import fbc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_containment
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_containment))
        else $error("Stalled result changed or dropped.");

    a_out_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_containment == CONT_OUTSIDE || m_containment == CONT_INTERSECT
                     || m_containment == CONT_INSIDE))
        else $error("Result carries an undefined containment code.");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("Input refused while the result stage is empty.");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

endmodule

bind frustum_box_classify_unit fbc_checker u_fbc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_containment (m_containment)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench of the frustum box unit: planes over APB, boxes in, classes out.
`timescale 1ns / 100ps

module tb_top;
    import fbc_pkg::*;

    typedef enum int {
        IDX_LEFT   = 0,
        IDX_RIGHT  = 1,
        IDX_BOTTOM = 2,
        IDX_TOP    = 3,
        IDX_NEAR   = 4,
        IDX_FAR    = 5,
        IDX_SPARE0 = 6,
        IDX_SPARE1 = 7
    } plane_idx_t;

    typedef enum int {
        PK_CUBE,
        PK_TILTED,
        PK_RANDOM,
        PK_EXTREME
    } plane_kind_t;

    localparam int ONE_Q14 = 16384;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [REG_W-1:0]  pwdata   = '0;
    logic [REG_W-1:0]  prdata;
    logic              pready;
    logic              s_valid  = 1'b0;
    logic              s_ready;
    box_t              drv_box  = '0;
    logic              m_valid;
    logic              m_ready  = 1'b1;
    logic [1:0]        m_containment;

    plane_t            plane_cfg [NUM_PLANES];
    plane_t            plane_next [NUM_PLANES];
    box_t              box_queue [$];
    containment_t      class_queue [$];
    containment_t      want;
    logic              box_taken = 1'b0;
    int                err_count = 0;
    int                class_seen [3] = '{0, 0, 0};
    int                load_count = 0;
    int                box_scale = 1600;
    int                snd_mode = 0;
    int                rcv_mode = 0;
    int                burst_left = 1;
    int                gap_left = 0;
    int                rdy_left = 0;
    logic              rdy_state = 1'b1;

    frustum_box_classify_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_box_min_x   (drv_box.min_x),
        .s_box_min_y   (drv_box.min_y),
        .s_box_min_z   (drv_box.min_z),
        .s_box_max_x   (drv_box.max_x),
        .s_box_max_y   (drv_box.max_y),
        .s_box_max_z   (drv_box.max_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_containment (m_containment)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic signed [COORD_W-1:0] clamp16(input int v);
        if (v > 32767) begin
            return 16'sd32767;
        end
        if (v < -32768) begin
            return -16'sd32768;
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic box_t mk_box(input int mnx, input int mny, input int mnz,
                                    input int mxx, input int mxy, input int mxz);
        box_t b;
        b.min_x = clamp16(mnx);
        b.min_y = clamp16(mny);
        b.min_z = clamp16(mnz);
        b.max_x = clamp16(mxx);
        b.max_y = clamp16(mxy);
        b.max_z = clamp16(mxz);
        return b;
    endfunction

    function automatic plane_t mk_plane(input int nx, input int ny, input int nz, input int d);
        plane_t p;
        p.nx = clamp16(nx);
        p.ny = clamp16(ny);
        p.nz = clamp16(nz);
        p.d  = clamp16(d);
        return p;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: begin
                return -32768;
            end
            1: begin
                return 32767;
            end
            2: begin
                return 0;
            end
            3: begin
                return -1;
            end
            default: begin
                return 1;
            end
        endcase
    endfunction

    // A zero normal component selects the maximum coordinate as the farthest corner.
    function automatic containment_t classify_box(input box_t b);
        longint lo [3];
        longint hi [3];
        longint nrm [3];
        longint pv [3];
        longint nv [3];
        longint off;
        longint dist_p;
        longint dist_n;
        int     inside_cnt;
        int     i;
        int     k;
        lo[0] = $signed(b.min_x);
        lo[1] = $signed(b.min_y);
        lo[2] = $signed(b.min_z);
        hi[0] = $signed(b.max_x);
        hi[1] = $signed(b.max_y);
        hi[2] = $signed(b.max_z);
        inside_cnt = 0;
        for (i = 0; i < NUM_PLANES; i++) begin
            nrm[0] = $signed(plane_cfg[i].nx);
            nrm[1] = $signed(plane_cfg[i].ny);
            nrm[2] = $signed(plane_cfg[i].nz);
            off    = $signed(plane_cfg[i].d);
            for (k = 0; k < 3; k++) begin
                pv[k] = (nrm[k] >= 0) ? hi[k] : lo[k];
                nv[k] = (nrm[k] >= 0) ? lo[k] : hi[k];
            end
            dist_p = nrm[0] * pv[0] + nrm[1] * pv[1] + nrm[2] * pv[2] + (off <<< OFFSET_SH);
            dist_n = nrm[0] * nv[0] + nrm[1] * nv[1] + nrm[2] * nv[2] + (off <<< OFFSET_SH);
            if (dist_p < 0) begin
                return CONT_OUTSIDE;
            end
            if (dist_n >= 0) begin
                inside_cnt++;
            end
        end
        return (inside_cnt == NUM_PLANES) ? CONT_INSIDE : CONT_INTERSECT;
    endfunction

    function automatic box_t rand_box(input int h);
        int   cx;
        int   cy;
        int   cz;
        int   ex;
        int   ey;
        int   ez;
        int   pick;
        box_t b;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            b = {$urandom, $urandom, $urandom};
        end else if (pick == 2) begin
            b = mk_box(pick_extreme(), pick_extreme(), pick_extreme(),
                       pick_extreme(), pick_extreme(), pick_extreme());
        end else begin
            cx = int'($urandom_range(0, 4 * h)) - 2 * h;
            cy = int'($urandom_range(0, 4 * h)) - 2 * h;
            cz = int'($urandom_range(0, 4 * h)) - 2 * h;
            ex = $urandom_range(0, h);
            ey = $urandom_range(0, h);
            ez = $urandom_range(0, h);
            b = mk_box(cx - ex, cy - ey, cz - ez, cx + ex, cy + ey, cz + ez);
            if (pick < 5) begin
                {b.min_x, b.max_x} = {b.max_x, b.min_x};
                {b.min_z, b.max_z} = {b.max_z, b.min_z};
            end
        end
        return b;
    endfunction

    task automatic apb_access(input bit wr, input int idx, input logic [REG_W-1:0] wdata,
                              output logic [REG_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx << IDX_LSB);
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_planes();
        logic [REG_W-1:0] unused;
        int               i;
        for (i = 0; i < NUM_PLANES; i++) begin
            apb_access(1'b1, i, plane_next[i], unused);
            plane_cfg[i] = plane_next[i];
        end
        load_count++;
    endtask

    task automatic check_planes();
        logic [REG_W-1:0] rd;
        int               i;
        for (i = 0; i < NUM_PLANES; i++) begin
            apb_access(1'b0, i, '0, rd);
            if (rd !== plane_cfg[i]) begin
                report_mismatch($sformatf("plane %0d reads %h, expected %h", i, rd, plane_cfg[i]));
            end
        end
    endtask

    // Plane order is left, right, bottom, top, near, far: axis x, y, z, sign +, -.
    task automatic build_planes(input plane_kind_t kind, input int h);
        int comp [3];
        int i;
        int k;
        int tilt;
        box_scale = h;
        for (i = 0; i < NUM_PLANES; i++) begin
            case (kind)
                PK_CUBE, PK_TILTED: begin
                    tilt = (kind == PK_TILTED) ? 6000 : 0;
                    for (k = 0; k < 3; k++) begin
                        comp[k] = int'($urandom_range(0, 2 * tilt)) - tilt;
                    end
                    comp[i / 2] = ((i % 2) == 0) ? ONE_Q14 : -ONE_Q14;
                    plane_next[i] = mk_plane(comp[0], comp[1], comp[2],
                                             h + int'($urandom_range(0, tilt / 8)));
                end
                PK_RANDOM: begin
                    plane_next[i] = {$urandom, $urandom};
                end
                default: begin
                    plane_next[i] = mk_plane(pick_extreme(), pick_extreme(), pick_extreme(),
                                             pick_extreme());
                end
            endcase
        end
    endtask

    task automatic wait_idle();
        while (box_queue.size() != 0 || s_valid || class_queue.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(input plane_kind_t kind, input int h, input int smode,
                             input int rmode, input int n, input bit hold);
        logic [REG_W-1:0] unused;
        int               j;
        wait_idle();
        build_planes(kind, h);
        load_planes();
        if (kind == PK_RANDOM) begin
            apb_access(1'b1, IDX_SPARE0, {$urandom, $urandom}, unused);
            apb_access(1'b1, IDX_SPARE1, {$urandom, $urandom}, unused);
        end
        check_planes();
        snd_mode = smode;
        rcv_mode = rmode;
        for (j = 0; j < n; j++) begin
            if (hold && j == n / 2) begin
                wait_idle();
            end
            box_queue.push_back(rand_box(box_scale));
        end
    endtask

    always @(negedge aclk) begin
        if (!s_valid || box_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (box_queue.size() != 0) begin
                drv_box <= box_queue.pop_front();
                s_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    case (snd_mode)
                        0: begin
                            burst_left = 1000;
                            gap_left   = 0;
                        end
                        1: begin
                            burst_left = $urandom_range(1, 16);
                            gap_left   = $urandom_range(0, 6);
                        end
                        default: begin
                            burst_left = $urandom_range(1, 4);
                            gap_left   = $urandom_range(1, 12);
                        end
                    endcase
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        box_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            class_queue.push_back(classify_box(drv_box));
        end
    end

    always @(negedge aclk) begin
        if (rdy_left > 0) begin
            rdy_left--;
        end else if (rcv_mode == 0) begin
            rdy_state = 1'b1;
            rdy_left  = $urandom_range(1, 32);
        end else begin
            rdy_state = !rdy_state;
            if (rdy_state) begin
                rdy_left = (rcv_mode == 1) ? $urandom_range(1, 12) : $urandom_range(0, 4);
            end else begin
                rdy_left = (rcv_mode == 1) ? $urandom_range(0, 2) : $urandom_range(0, 9);
            end
        end
        m_ready <= rdy_state;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (class_queue.size() == 0) begin
                report_mismatch($sformatf("result %0d with no box outstanding", m_containment));
            end else begin
                want = class_queue.pop_front();
                if (m_containment !== want) begin
                    report_mismatch($sformatf("containment %0d, expected %0d",
                                              m_containment, want));
                end
                if (m_containment < 3) begin
                    class_seen[m_containment]++;
                end
            end
        end
    end

    initial begin
        int h;
        int i;
        for (i = 0; i < NUM_PLANES; i++) begin
            plane_cfg[i] = '0;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // All planes are zero after reset, so every box is fully inside.
        check_planes();
        snd_mode = 1;
        rcv_mode = 1;
        box_queue.push_back(mk_box(0, 0, 0, 0, 0, 0));
        box_queue.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        box_queue.push_back(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        box_queue.push_back(rand_box(1600));
        wait_idle();

        // Axis-aligned cube frustum: zero normal components on every plane.
        h = 1600;
        build_planes(PK_CUBE, h);
        for (i = 0; i < NUM_PLANES; i++) begin
            plane_next[i].d = h;
        end
        load_planes();
        check_planes();
        box_queue.push_back(mk_box(-160, -160, -160, 160, 160, 160));
        box_queue.push_back(mk_box(-300, 0, 0, -h - 16, 16, 16));
        box_queue.push_back(mk_box(h + 16, 0, 0, h + 300, 16, 16));
        box_queue.push_back(mk_box(0, -h - 300, 0, 16, -h - 16, 16));
        box_queue.push_back(mk_box(0, h + 16, 0, 16, h + 300, 16));
        box_queue.push_back(mk_box(0, 0, -h - 300, 16, 16, -h - 16));
        box_queue.push_back(mk_box(0, 0, h + 16, 16, 16, h + 300));
        box_queue.push_back(mk_box(-16, -16, -16, h + 16, 16, 16));
        box_queue.push_back(mk_box(-h, -h, -h, h, h, h));
        box_queue.push_back(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        box_queue.push_back(mk_box(160, 160, 160, -160, -160, -160));
        box_queue.push_back(mk_box(-h - 160, 0, 0, -h, 16, 16));

        run_phase(PK_CUBE,    $urandom_range(64, 12000), 0, 0, 250, 1'b0);
        run_phase(PK_TILTED,  $urandom_range(64, 12000), 1, 1, 250, 1'b1);
        run_phase(PK_RANDOM,  $urandom_range(16, 16000), 2, 1, 250, 1'b0);
        run_phase(PK_EXTREME, $urandom_range(16, 16000), 1, 2, 250, 1'b0);
        run_phase(PK_TILTED,  $urandom_range(64, 12000), 2, 2, 250, 1'b0);
        run_phase(PK_CUBE,    $urandom_range(16, 200),   0, 2, 250, 1'b1);

        wait_idle();
        repeat (16) @(posedge aclk);
        $display("Checked %0d outside, %0d intersecting and %0d inside boxes.",
                 class_seen[CONT_OUTSIDE], class_seen[CONT_INTERSECT], class_seen[CONT_INSIDE]);
        $display("Plane sets loaded: %0d (cube, tilted, random and extreme), mismatches: %0d.",
                 load_count, err_count);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding.", class_queue.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
